### design/salc_pkg.sv
// Shared types and constants of the set-associative LRU cache controller.
`default_nettype none

package salc_pkg;

  // Access kinds carried by the opcode field.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_WRITE_ALLOCATE = 1'b0;
  localparam logic CFG_WRITE_BACK     = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // take the request word and start the set read
    logic decide;     // set row is on the RAM output; prepare the victim scan
    logic scan_step;  // compare one more way against the oldest so far
    logic commit;     // write the set row back unless the write bypasses, and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;  // miss that must evict: every way is valid
    logic scan_last;  // the scan compares its last way this cycle
    logic out_busy;   // result register holds a word that is not taken
  } sts_t;

endpackage

`default_nettype wire

### design/salc_if.sv
// Request and response channel interfaces of the cache controller.
`default_nettype none

interface salc_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] address;

  modport source (output valid, output opcode, output address, input ready);
  modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface salc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [1:0]  way;
  logic        fill;
  logic        evict_writeback;
  logic [31:0] victim_block_address;
  logic        direct_write;
  logic        through_write;
  logic [31:0] hit_total;

  modport source (output valid, output hit, output way, output fill, output evict_writeback,
                  output victim_block_address, output direct_write, output through_write,
                  output hit_total, input ready);
  modport sink   (input valid, input hit, input way, input fill, input evict_writeback,
                  input victim_block_address, input direct_write, input through_write,
                  input hit_total, output ready);
endinterface

`default_nettype wire

### design/salc_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]      wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AW-1:0]         raddr_i,
  output      logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### design/salc_ctrl.sv
// Controller state machine of the cache controller.
`default_nettype none

module salc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output      logic          req_ready_o,
  input  wire salc_pkg::sts_t sts_i,
  output      salc_pkg::cmd_t cmd_o
);

  salc_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= salc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      salc_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = salc_pkg::ST_LOOKUP;
        end
      end
      salc_pkg::ST_LOOKUP: begin
        cmd_o.decide = 1'b1;
        if (sts_i.need_scan) begin
          state_d = salc_pkg::ST_SCAN;
        end else if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = salc_pkg::ST_IDLE;
        end else begin
          state_d = salc_pkg::ST_DONE;
        end
      end
      salc_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = salc_pkg::ST_DONE;
        end
      end
      salc_pkg::ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = salc_pkg::ST_IDLE;
        end
      end
      default: state_d = salc_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### design/salc_datapath.sv
// Datapath of the cache controller: set RAM, valid bits, lookup, LRU scan, result register.
`default_nettype none

module salc_datapath #(
  parameter int NUM_WAYS    = 4,
  parameter int NUM_SETS    = 64,
  parameter int BLOCK_BYTES = 32,
  parameter int ADDR_BITS   = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire salc_pkg::cmd_t cmd_i,
  output      salc_pkg::sts_t sts_o,
  input  wire logic           req_opcode_i,
  input  wire logic [31:0]    req_address_i,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_index_i,
  input  wire logic           cfg_data_i,
  salc_rsp_if.source          rsp_o
);

  // Address split; NUM_SETS and BLOCK_BYTES are powers of two.
  localparam int OFFW  = $clog2(BLOCK_BYTES);
  localparam int IDXW  = $clog2(NUM_SETS);
  localparam int SETAW = (IDXW > 0) ? IDXW : 1;
  localparam int TAGW  = ADDR_BITS - OFFW - IDXW;
  localparam int WAYW  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int EW    = TAGW + 33;            // dirty, tag, stamp
  localparam int RW    = NUM_WAYS * EW;
  localparam logic [31:0] AMASK = 32'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [31:0] SMASK = 32'(NUM_SETS - 1);

  // Request, configuration and counters.
  logic             op_q;
  logic [SETAW-1:0] set_q;
  logic [TAGW-1:0]  tag_q;
  logic             wa_q, wb_q;
  logic [31:0]      use_clk_q, hit_cnt_q;
  logic [NUM_SETS-1:0][NUM_WAYS-1:0] valid_q;
  logic [WAYW-1:0]  cnt_q, best_q;

  // Result register.
  logic        out_valid_q;
  logic        o_hit_q, o_fill_q, o_evict_q, o_direct_q, o_through_q;
  logic [1:0]  o_way_q;
  logic [31:0] o_victim_q, o_total_q;

  logic [31:0]      addr_in;
  logic [SETAW-1:0] set_in;
  logic [TAGW-1:0]  tag_in;
  logic [RW-1:0]    rd_data, wr_data;
  logic             ram_we;

  logic [TAGW-1:0]     e_tag   [NUM_WAYS];
  logic [31:0]         e_stamp [NUM_WAYS];
  logic [NUM_WAYS-1:0] e_dirty;
  logic [NUM_WAYS-1:0] row_valid;

  logic            hit, any_inv, direct, fill, evict, through, is_write;
  logic [WAYW-1:0] hit_way, inv_way, sel_way;
  logic [31:0]     clk_next, hit_next, victim_addr;
  logic            new_dirty;
  logic [TAGW-1:0] new_tag;
  logic            out_busy;

  assign addr_in = req_address_i & AMASK;
  assign set_in  = SETAW'((addr_in >> OFFW) & SMASK);
  assign tag_in  = TAGW'(addr_in >> (OFFW + IDXW));

  // Set RAM: one row per set, one entry per way.
  salc_ram #(.WIDTH(RW), .DEPTH(NUM_SETS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (set_q),
    .wdata_i (wr_data),
    .re_i    (cmd_i.accept),
    .raddr_i (set_in),
    .rdata_o (rd_data)
  );

  // Take the request word apart.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= req_opcode_i;
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_q <= 1'b1;
      wb_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        salc_pkg::CFG_WRITE_ALLOCATE: wa_q <= cfg_data_i;
        salc_pkg::CFG_WRITE_BACK:     wb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the set row.
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      e_stamp[w] = rd_data[w*EW +: 32];
      e_tag[w]   = rd_data[w*EW + 32 +: TAGW];
      e_dirty[w] = rd_data[w*EW + EW - 1];
    end
  end

  assign row_valid = valid_q[set_q];

  // Hit search and first invalid way, lowest way wins.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row_valid[w] && (e_tag[w] == tag_q)) begin
        hit     = 1'b1;
        hit_way = WAYW'(w);
      end
      if (!row_valid[w]) begin
        any_inv = 1'b1;
        inv_way = WAYW'(w);
      end
    end
  end

  assign is_write = (op_q == salc_pkg::OP_WRITE);
  assign direct   = !hit && is_write && !wa_q;
  assign fill     = !hit && !direct;
  assign sel_way  = hit ? hit_way : (any_inv ? inv_way : best_q);
  assign evict    = fill && !any_inv && e_dirty[sel_way];
  assign through  = is_write && !direct && !wb_q;
  assign clk_next = use_clk_q + 32'd1;
  assign hit_next = (hit && (hit_cnt_q != '1)) ? hit_cnt_q + 32'd1 : hit_cnt_q;
  assign victim_addr = evict ? ((32'(e_tag[sel_way]) << (OFFW + IDXW)) | (32'(set_q) << OFFW))
                             : 32'd0;

  // Oldest-stamp scan, one way per cycle; strict compare keeps the lowest way on ties.
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      best_q <= '0;
      cnt_q  <= WAYW'(1);
    end else if (cmd_i.scan_step) begin
      if (e_stamp[cnt_q] < e_stamp[best_q]) begin
        best_q <= cnt_q;
      end
      cnt_q <= cnt_q + WAYW'(1);
    end
  end

  // Updated entry of the way that serves the access.
  always_comb begin
    new_tag   = fill ? tag_q : e_tag[sel_way];
    new_dirty = fill ? 1'b0 : e_dirty[sel_way];
    if (is_write && wb_q) begin
      new_dirty = 1'b1;
    end
    wr_data = rd_data;
    wr_data[sel_way*EW +: EW] = {new_dirty, new_tag, clk_next};
  end

  assign ram_we = cmd_i.commit && !direct;

  // Valid bits, use clock and hit counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      use_clk_q <= '0;
      hit_cnt_q <= '0;
    end else if (cmd_i.commit) begin
      hit_cnt_q <= hit_next;
      if (!direct) begin
        use_clk_q                <= clk_next;
        valid_q[set_q][sel_way]  <= 1'b1;
      end
    end
  end

  // Result register handshake.
  assign out_busy = out_valid_q && !rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      o_hit_q     <= hit;
      o_way_q     <= direct ? 2'd0 : 2'(sel_way);
      o_fill_q    <= fill;
      o_evict_q   <= evict;
      o_victim_q  <= victim_addr;
      o_direct_q  <= direct;
      o_through_q <= through;
      o_total_q   <= hit_next;
    end
  end

  assign rsp_o.valid                = out_valid_q;
  assign rsp_o.hit                  = o_hit_q;
  assign rsp_o.way                  = o_way_q;
  assign rsp_o.fill                 = o_fill_q;
  assign rsp_o.evict_writeback      = o_evict_q;
  assign rsp_o.victim_block_address = o_victim_q;
  assign rsp_o.direct_write         = o_direct_q;
  assign rsp_o.through_write        = o_through_q;
  assign rsp_o.hit_total            = o_total_q;

  assign sts_o.need_scan = !hit && !direct && !any_inv && (NUM_WAYS > 1);
  assign sts_o.scan_last = (cnt_q == WAYW'(NUM_WAYS - 1));
  assign sts_o.out_busy  = out_busy;

  // A result is only loaded into a free register.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !out_busy) else $error("result register overwritten");

  // A commit always presents a word next cycle.
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q) else $error("committed word not shown");

  // An eviction only happens on a fill.
  a_evict_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_evict_q |-> o_fill_q) else $error("eviction without fill");

  // A bypassed write neither hits nor fills.
  a_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_direct_q |-> !o_hit_q && !o_fill_q && !o_through_q)
    else $error("bypassed write touched the cache");

endmodule

`default_nettype wire

### design/set_assoc_lru_cache_controller.sv
// A hit, a fill into an invalid way or a bypassed write commits in the lookup state or, if the
// result register is busy, in the done state once it is free. A miss into a full set first
// passes the LRU scan state (one way per cycle), then commits in the done state; a new access
// waits for commit. The result register lets a new access start while the previous result waits.
// Reset clears all valid bits, the use clock and the hit counter at once; no clearing pass.
`default_nettype none

module set_assoc_lru_cache_controller #(
  parameter int NUM_WAYS    = 4,
  parameter int NUM_SETS    = 64,
  parameter int BLOCK_BYTES = 32,
  parameter int ADDR_BITS   = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  salc_req_if.sink   req_i,
  salc_rsp_if.source rsp_o,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_index_i,
  input  wire logic  cfg_data_i
);

  salc_pkg::cmd_t cmd;
  salc_pkg::sts_t sts;

  // Controller.
  salc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  salc_datapath #(
    .NUM_WAYS    (NUM_WAYS),
    .NUM_SETS    (NUM_SETS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_opcode_i  (req_i.opcode),
    .req_address_i (req_i.address),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .rsp_o         (rsp_o)
  );

endmodule

`default_nettype wire

### dv/tb_salc_checker.sv
// Checker of the cache controller: predicts each access result and compares it.
`default_nettype none

module tb_salc_checker (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  salc_req_if        req_i,
  salc_rsp_if        rsp_i,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_index_i,
  input  wire logic  cfg_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam int WAYS = 4;
  localparam int SETS = 64;

  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic        fill;
    logic        evict_writeback;
    logic [31:0] victim_block_address;
    logic        direct_write;
    logic        through_write;
    logic [31:0] hit_total;
  } access_result_t;

  logic        alloc_on_write;
  logic        mark_dirty;
  logic        valid_q  [SETS][WAYS];
  logic        dirty_q  [SETS][WAYS];
  logic [20:0] tag_q    [SETS][WAYS];
  logic [31:0] stamp_q  [SETS][WAYS];
  logic [31:0] use_clock;
  logic [31:0] hits;
  access_result_t expected_results[$];

  assign pending_o = expected_results.size();

  // Work out the result of one access and update the cache state.
  function automatic access_result_t predict_access(logic is_write, logic [31:0] addr);
    access_result_t r;
    logic [5:0]  set;
    logic [20:0] tag;
    int          w;
    int          best;
    logic        found;
    r = '0;
    set = addr[10:5];
    tag = addr[31:11];
    found = 1'b0;
    for (w = 0; w < WAYS; w++) begin
      if (!found && valid_q[set][w] && tag_q[set][w] == tag) begin
        found = 1'b1;
        r.way = w[1:0];
      end
    end
    r.hit = found;
    if (found) begin
      if (hits != 32'hFFFF_FFFF) hits = hits + 1;
    end else if (is_write && !alloc_on_write) begin
      r.direct_write = 1'b1;
    end else begin
      // Lowest invalid way first, else the oldest stamp with ties to the lowest way.
      best = -1;
      for (w = 0; w < WAYS; w++) begin
        if (best < 0 && !valid_q[set][w]) best = w;
      end
      if (best < 0) begin
        best = 0;
        for (w = 1; w < WAYS; w++) begin
          if (stamp_q[set][w] < stamp_q[set][best]) best = w;
        end
      end
      r.way = best[1:0];
      if (valid_q[set][best] && dirty_q[set][best]) begin
        r.evict_writeback = 1'b1;
        r.victim_block_address = {tag_q[set][best], set, 5'b0};
      end
      tag_q[set][best] = tag;
      valid_q[set][best] = 1'b1;
      dirty_q[set][best] = 1'b0;
      r.fill = 1'b1;
    end
    if (!r.direct_write) begin
      use_clock = use_clock + 1;
      stamp_q[set][r.way] = use_clock;
      if (is_write) begin
        if (mark_dirty) dirty_q[set][r.way] = 1'b1;
        else r.through_write = 1'b1;
      end
    end
    r.hit_total = hits;
    return r;
  endfunction

  // Watch both channels and the configuration port on each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t e;
    access_result_t a;
    if (!rst_ni) begin
      alloc_on_write = 1'b1;
      mark_dirty = 1'b1;
      use_clock = '0;
      hits = '0;
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          valid_q[s][w] = 1'b0;
          dirty_q[s][w] = 1'b0;
          tag_q[s][w] = '0;
          stamp_q[s][w] = '0;
        end
      end
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == salc_pkg::CFG_WRITE_ALLOCATE) alloc_on_write = cfg_data_i;
        else mark_dirty = cfg_data_i;
      end
      if (req_i.valid && req_i.ready) begin
        expected_results.push_back(predict_access(req_i.opcode == salc_pkg::OP_WRITE,
                                                  req_i.address));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        a = '{rsp_i.hit, rsp_i.way, rsp_i.fill, rsp_i.evict_writeback,
              rsp_i.victim_block_address, rsp_i.direct_write, rsp_i.through_write,
              rsp_i.hit_total};
        if (expected_results.size() == 0) begin
          $error("result word with no access pending");
          fail_count_o++;
        end else begin
          e = expected_results.pop_front();
          if (a.hit !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, a.hit); fail_count_o++;
          end
          if (a.way !== e.way) begin
            $error("way: expected %0d, got %0d", e.way, a.way); fail_count_o++;
          end
          if (a.fill !== e.fill) begin
            $error("fill: expected %0d, got %0d", e.fill, a.fill); fail_count_o++;
          end
          if (a.evict_writeback !== e.evict_writeback) begin
            $error("evict_writeback: expected %0d, got %0d", e.evict_writeback,
                   a.evict_writeback);
            fail_count_o++;
          end
          if (a.victim_block_address !== e.victim_block_address) begin
            $error("victim_block_address: expected %h, got %h", e.victim_block_address,
                   a.victim_block_address);
            fail_count_o++;
          end
          if (a.direct_write !== e.direct_write) begin
            $error("direct_write: expected %0d, got %0d", e.direct_write, a.direct_write);
            fail_count_o++;
          end
          if (a.through_write !== e.through_write) begin
            $error("through_write: expected %0d, got %0d", e.through_write, a.through_write);
            fail_count_o++;
          end
          if (a.hit_total !== e.hit_total) begin
            $error("hit_total: expected %0d, got %0d", e.hit_total, a.hit_total);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

### dv/tb_top.sv
// Top of the cache controller testbench: clock, reset, access stimulus and verdict.
`default_nettype none

module tb_top;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic cfg_data_i = 1'b0;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  int   accesses_sent = 0;
  bit   no_idle = 1'b0;
  bit   hold_off = 1'b0;

  salc_req_if req ();
  salc_rsp_if rsp ();

  set_assoc_lru_cache_controller dut (
    .clk_i, .rst_ni, .req_i(req), .rsp_o(rsp), .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  tb_salc_checker checker_u (
    .clk_i, .rst_ni, .req_i(req), .rsp_i(rsp), .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #1 clk_i = ~clk_i;

  // Response side: random stalls, a calm stretch, and one long hold-off.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        rsp.ready <= 1'b0;
        repeat (60) @(negedge clk_i);
        hold_off = 1'b0;
      end
      rsp.ready <= no_idle || ($urandom_range(99) >= 27);
    end
  end

  // Watchdog on cycles with no accepted word on either channel.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one access, with a random gap beforehand unless idling is off.
  // Valid stays high after an accept until the next word or a gap replaces it.
  task automatic send_access(logic op, logic [31:0] addr);
    while (!no_idle && $urandom_range(99) < 27) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.address <= addr;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
    accesses_sent++;
  endtask

  // Let every result arrive and the block settle before a register write.
  task automatic write_config(logic index, logic value);
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Address built from tag, set and offset; a small tag span makes sets fill and evict.
  function automatic logic [31:0] pick_address(int tag_span, int set_span);
    logic [20:0] tag;
    tag = (tag_span == 0) ? 21'($urandom) : 21'($urandom_range(tag_span));
    if ($urandom_range(9) == 0) tag = 21'h1F_FFFF;
    return {tag, 6'($urandom_range(set_span)), 5'($urandom)};
  endfunction

  initial begin
    req.valid = 1'b0;
    req.opcode = salc_pkg::OP_READ;
    req.address = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: fill one set, hits, evict dirty lines, address extremes.
    send_access(salc_pkg::OP_WRITE, 32'h0000_0000);
    send_access(salc_pkg::OP_READ, 32'h0000_001F);
    send_access(salc_pkg::OP_WRITE, 32'hFFFF_FFFF);
    send_access(salc_pkg::OP_READ, 32'hFFFF_FFE0);
    for (int t = 1; t <= 5; t++) send_access(salc_pkg::OP_WRITE, {21'(t), 6'd0, 5'd3});
    send_access(salc_pkg::OP_READ, 32'h0000_0000);
    write_config(salc_pkg::CFG_WRITE_BACK, 1'b0);
    send_access(salc_pkg::OP_WRITE, {21'd5, 6'd0, 5'd0});
    send_access(salc_pkg::OP_WRITE, {21'd9, 6'd0, 5'd0});
    write_config(salc_pkg::CFG_WRITE_ALLOCATE, 1'b0);
    send_access(salc_pkg::OP_WRITE, {21'd77, 6'd0, 5'd0});
    send_access(salc_pkg::OP_READ, {21'd77, 6'd0, 5'd0});
    send_access(salc_pkg::OP_WRITE, 32'hAAAA_AAAA);
    send_access(salc_pkg::OP_WRITE, 32'h5555_5555);

    // Random phases across all four register settings.
    for (int phase = 0; phase < 8; phase++) begin
      write_config(salc_pkg::CFG_WRITE_ALLOCATE, phase[0]);
      write_config(salc_pkg::CFG_WRITE_BACK, phase[1]);
      no_idle = (phase == 3);
      if (phase == 5) hold_off = 1'b1;
      for (int i = 0; i < 170; i++) begin
        send_access(logic'($urandom), (phase == 7) ? pick_address(0, 63)
                                                   : pick_address(7, 3));
      end
    end
    no_idle = 1'b0;
    req.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

`default_nettype wire
